// ===== rtl/sed_pkg.sv =====
// Shared types, character codes and helper functions for the string escape decoder.
// Used by string_escape_decoder_core; depends on nothing else.
`default_nettype none
package sed_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       raw_mode;
    logic       final_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       bad_hex;
    logic       literal_end;
    logic       run_last;
  } out_item_t;

  typedef enum logic [4:0] {
    MODE_NORMAL = 5'b00001,
    MODE_ESC    = 5'b00010,
    MODE_OCT    = 5'b00100,
    MODE_HEX0   = 5'b01000,
    MODE_HEX1   = 5'b10000
  } mode_t;

  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_QUOTE  = 8'h27;
  localparam logic [7:0] CHAR_DQUOTE = 8'h22;
  localparam logic [7:0] CHAR_X      = 8'h78;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_SEVEN  = 8'h37;

  localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

  // Result entry with all fields clear.
  localparam out_item_t NO_ITEM = '{out_byte: 8'h00, byte_valid: 1'b0, bad_hex: 1'b0,
                                     literal_end: 1'b0, run_last: 1'b0};

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    else v = 8'h00;
    return v[3:0];
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
  endfunction

  function automatic out_item_t mk_item(input logic [7:0] b, input logic valid,
                                        input logic bad);
    out_item_t r;
    r = NO_ITEM;
    r.out_byte   = valid ? b : 8'h00;
    r.byte_valid = valid;
    r.bad_hex    = bad;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/string_escape_decoder_core.sv =====
// Top level of the string escape decoder: decode state, escape logic and result buffer.
// Depends on sed_pkg for item types, mode codes and character helpers.
`default_nettype none
// Decodes the body of one string literal, one byte per input transaction, into
// result transactions of decoded bytes (CR LF and lone CR become LF; escapes are
// decoded unless raw_mode is set). Each input byte is decoded in the cycle it is
// accepted and its zero, one or two results land in a two-entry result buffer.
// While the output side keeps up, an item that yields at most one result leaves room for
// the next, so a steady stream runs at one byte per cycle; an item that yields two
// results fills the buffer, which stalls the input until the first of them is taken.
// The item flagged final_char always yields at least one result,
// carries literal_end on its last result and returns the decoder to reset state.
module string_escape_decoder_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire sed_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output sed_pkg::out_item_t      out_data
);

  sed_pkg::mode_t     mode_r, mode_nxt;
  logic [8:0]         oacc_r, oacc_nxt;
  logic [1:0]         ocnt_r, ocnt_nxt;
  logic [7:0]         hfd_r, hfd_nxt;
  logic               after_cr_r, after_cr_nxt;

  sed_pkg::out_item_t slot0_r, slot0_nxt, slot1_r, slot1_nxt;
  logic [1:0]         cnt_r, cnt_nxt;

  logic               in_acc, out_acc;

  // Decode stage results.
  sed_pkg::mode_t     md;
  logic [8:0]         macc;
  logic [1:0]         mcnt;
  logic [7:0]         mhfd;
  sed_pkg::out_item_t d0, d1, fl, r0, r1;
  logic [1:0]         dn, rn;
  logic               fn;
  logic [7:0]         c;
  logic               drop;
  logic [8:0]         oacc_step;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign out_acc   = out_valid && !out_stall;
  assign in_stall  = (cnt_r == 2'd2) || ((cnt_r == 2'd1) && out_stall);
  assign in_acc    = in_valid && !in_stall;

  assign oacc_step = {oacc_r[5:0], 3'(c - sed_pkg::CHAR_ZERO)};

  always_comb begin
    drop = after_cr_r && (in_data.in_char == sed_pkg::CHAR_LF);
    c    = (in_data.in_char == sed_pkg::CHAR_CR) ? sed_pkg::CHAR_LF : in_data.in_char;
    md   = mode_r;
    macc = oacc_r;
    mcnt = ocnt_r;
    mhfd = hfd_r;
    d0   = sed_pkg::NO_ITEM;
    d1   = sed_pkg::NO_ITEM;
    dn   = 2'd0;

    if (drop) begin
      // The LF of a CR LF pair was already produced by the CR.
    end else if (in_data.raw_mode) begin
      d0 = sed_pkg::mk_item(c, 1'b1, 1'b0);
      dn = 2'd1;
    end else begin
      case (mode_r)
        sed_pkg::MODE_ESC: begin
          md = sed_pkg::MODE_NORMAL;
          dn = 2'd1;
          case (c)
            sed_pkg::CHAR_LF: dn = 2'd0;
            8'h61: d0 = sed_pkg::mk_item(8'h07, 1'b1, 1'b0);
            8'h62: d0 = sed_pkg::mk_item(8'h08, 1'b1, 1'b0);
            8'h66: d0 = sed_pkg::mk_item(8'h0C, 1'b1, 1'b0);
            8'h6E: d0 = sed_pkg::mk_item(8'h0A, 1'b1, 1'b0);
            8'h72: d0 = sed_pkg::mk_item(8'h0D, 1'b1, 1'b0);
            8'h74: d0 = sed_pkg::mk_item(8'h09, 1'b1, 1'b0);
            8'h76: d0 = sed_pkg::mk_item(8'h0B, 1'b1, 1'b0);
            sed_pkg::CHAR_QUOTE, sed_pkg::CHAR_DQUOTE, sed_pkg::CHAR_BSLASH:
              d0 = sed_pkg::mk_item(c, 1'b1, 1'b0);
            sed_pkg::CHAR_X: begin
              md = sed_pkg::MODE_HEX0;
              dn = 2'd0;
            end
            default: begin
              if (sed_pkg::is_oct(c)) begin
                md   = sed_pkg::MODE_OCT;
                macc = {6'd0, 3'(c - sed_pkg::CHAR_ZERO)};
                mcnt = 2'd1;
                dn   = 2'd0;
              end else begin
                // Unknown escape keeps its backslash.
                d0 = sed_pkg::mk_item(sed_pkg::CHAR_BSLASH, 1'b1, 1'b0);
                d1 = sed_pkg::mk_item(c, 1'b1, 1'b0);
                dn = 2'd2;
              end
            end
          endcase
        end
        sed_pkg::MODE_OCT: begin
          if (sed_pkg::is_oct(c) && (ocnt_r < sed_pkg::OCT_MAX_DIGITS)) begin
            macc = oacc_step;
            mcnt = ocnt_r + 2'd1;
            if (mcnt == sed_pkg::OCT_MAX_DIGITS) begin
              d0 = sed_pkg::mk_item(oacc_step[7:0], 1'b1, 1'b0);
              dn = 2'd1;
              md = sed_pkg::MODE_NORMAL;
            end
          end else begin
            d0 = sed_pkg::mk_item(oacc_r[7:0], 1'b1, 1'b0);
            if (c == sed_pkg::CHAR_BSLASH) begin
              md = sed_pkg::MODE_ESC;
              dn = 2'd1;
            end else begin
              md = sed_pkg::MODE_NORMAL;
              d1 = sed_pkg::mk_item(c, 1'b1, 1'b0);
              dn = 2'd2;
            end
          end
        end
        sed_pkg::MODE_HEX0, sed_pkg::MODE_HEX1: begin
          if (sed_pkg::is_hex(c)) begin
            if (mode_r == sed_pkg::MODE_HEX0) begin
              mhfd = c;
              md   = sed_pkg::MODE_HEX1;
            end else begin
              d0 = sed_pkg::mk_item({sed_pkg::hex_val(hfd_r), sed_pkg::hex_val(c)},
                                    1'b1, 1'b0);
              dn = 2'd1;
              md = sed_pkg::MODE_NORMAL;
            end
          end else begin
            // A broken hex escape is flagged and the breaking byte decodes as plain.
            d0 = sed_pkg::mk_item(hfd_r, (mode_r == sed_pkg::MODE_HEX1), 1'b1);
            if (c == sed_pkg::CHAR_BSLASH) begin
              md = sed_pkg::MODE_ESC;
              dn = 2'd1;
            end else begin
              md = sed_pkg::MODE_NORMAL;
              d1 = sed_pkg::mk_item(c, 1'b1, 1'b0);
              dn = 2'd2;
            end
          end
        end
        default: begin
          if (c == sed_pkg::CHAR_BSLASH) begin
            md = sed_pkg::MODE_ESC;
          end else begin
            md = sed_pkg::MODE_NORMAL;
            d0 = sed_pkg::mk_item(c, 1'b1, 1'b0);
            dn = 2'd1;
          end
        end
      endcase
    end

    // Flush of whatever escape is still pending after this byte.
    fn = 1'b1;
    case (md)
      sed_pkg::MODE_ESC:  fl = sed_pkg::mk_item(sed_pkg::CHAR_BSLASH, 1'b1, 1'b0);
      sed_pkg::MODE_OCT:  fl = sed_pkg::mk_item(macc[7:0], 1'b1, 1'b0);
      sed_pkg::MODE_HEX0: fl = sed_pkg::mk_item(8'h00, 1'b0, 1'b1);
      sed_pkg::MODE_HEX1: fl = sed_pkg::mk_item(mhfd, 1'b1, 1'b1);
      default: begin
        fl = sed_pkg::NO_ITEM;
        fn = 1'b0;
      end
    endcase

    // At most two results survive; an empty final item still reports the end.
    r0 = d0;
    r1 = d1;
    rn = dn;
    if (in_data.final_char) begin
      if (dn == 2'd0) begin
        r0 = fn ? fl : sed_pkg::NO_ITEM;
        rn = 2'd1;
      end else if ((dn == 2'd1) && fn) begin
        r1 = fl;
        rn = 2'd2;
      end
    end
    if (rn == 2'd2) begin
      r1.run_last    = 1'b1;
      r1.literal_end = in_data.final_char;
    end else begin
      r0.run_last    = 1'b1;
      r0.literal_end = in_data.final_char;
    end

    after_cr_nxt = after_cr_r;
    mode_nxt     = mode_r;
    oacc_nxt     = oacc_r;
    ocnt_nxt     = ocnt_r;
    hfd_nxt      = hfd_r;
    if (in_acc) begin
      after_cr_nxt = (in_data.in_char == sed_pkg::CHAR_CR);
      if (in_data.final_char) begin
        mode_nxt     = sed_pkg::MODE_NORMAL;
        oacc_nxt     = 9'd0;
        ocnt_nxt     = 2'd0;
        hfd_nxt      = 8'h00;
        after_cr_nxt = 1'b0;
      end else begin
        mode_nxt = md;
        oacc_nxt = macc;
        ocnt_nxt = mcnt;
        hfd_nxt  = mhfd;
      end
    end

    // Result buffer: pop the head, then load a new item's results.
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (out_acc) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end
    if (in_acc) begin
      slot0_nxt = r0;
      slot1_nxt = r1;
      cnt_nxt   = rn;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= sed_pkg::MODE_NORMAL;
      oacc_r     <= 9'd0;
      ocnt_r     <= 2'd0;
      hfd_r      <= 8'h00;
      after_cr_r <= 1'b0;
      cnt_r      <= 2'd0;
    end else begin
      mode_r     <= mode_nxt;
      oacc_r     <= oacc_nxt;
      ocnt_r     <= ocnt_nxt;
      hfd_r      <= hfd_nxt;
      after_cr_r <= after_cr_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_head_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.run_last) |-> (cnt_r == 2'd2))
    else $error("first of two results without its companion");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.literal_end) |-> out_data.run_last)
    else $error("literal end not on last result of its item");

  a_final_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.final_char) |=> (mode_r == sed_pkg::MODE_NORMAL && !after_cr_r))
    else $error("decoder state not cleared after final item");

  a_final_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.final_char) |=> out_valid)
    else $error("final item produced no result");

endmodule
`default_nettype wire

// ===== sim/sed_decode_checker.sv =====
// Checker for string_escape_decoder_core: watches both channels, predicts the decoded
// results of every accepted input transaction and compares them in order.
// Depends on sed_pkg for the item types and character codes.
module sed_decode_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  sed_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  sed_pkg::out_item_t out_data,
  output int                 mismatches,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  sed_pkg::mode_t dec_mode;
  logic [8:0]     oct_acc;
  logic [1:0]     oct_cnt;
  logic [7:0]     hex_first;
  logic           after_cr;

  // Results of the transaction being predicted; never more than two.
  sed_pkg::out_item_t step_res [2];
  int                 step_n;
  sed_pkg::out_item_t decoded_q [$];
  int                 err_cnt = 0;
  int                 result_idx = 0;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void clear_state();
    dec_mode  = sed_pkg::MODE_NORMAL;
    oct_acc   = '0;
    oct_cnt   = '0;
    hex_first = '0;
    after_cr  = 1'b0;
  endfunction

  function automatic void put_byte(input logic [7:0] b, input logic valid, input logic bad);
    sed_pkg::out_item_t r;
    if (step_n < 2) begin
      r             = '0;
      r.out_byte    = valid ? b : 8'h00;
      r.byte_valid  = valid;
      r.bad_hex     = bad;
      step_res[step_n] = r;
      step_n++;
    end
  endfunction

  function automatic void plain_byte(input logic [7:0] c);
    dec_mode = sed_pkg::MODE_NORMAL;
    if (c == sed_pkg::CHAR_BSLASH) dec_mode = sed_pkg::MODE_ESC;
    else put_byte(c, 1'b1, 1'b0);
  endfunction

  function automatic void escape_byte(input logic [7:0] c);
    dec_mode = sed_pkg::MODE_NORMAL;
    case (c)
      sed_pkg::CHAR_LF: ;
      "a": put_byte(8'h07, 1'b1, 1'b0);
      "b": put_byte(8'h08, 1'b1, 1'b0);
      "f": put_byte(8'h0C, 1'b1, 1'b0);
      "n": put_byte(8'h0A, 1'b1, 1'b0);
      "r": put_byte(8'h0D, 1'b1, 1'b0);
      "t": put_byte(8'h09, 1'b1, 1'b0);
      "v": put_byte(8'h0B, 1'b1, 1'b0);
      sed_pkg::CHAR_QUOTE, sed_pkg::CHAR_DQUOTE, sed_pkg::CHAR_BSLASH:
        put_byte(c, 1'b1, 1'b0);
      sed_pkg::CHAR_X: dec_mode = sed_pkg::MODE_HEX0;
      default: begin
        if (c >= sed_pkg::CHAR_ZERO && c <= sed_pkg::CHAR_SEVEN) begin
          dec_mode = sed_pkg::MODE_OCT;
          oct_acc  = 9'(c - sed_pkg::CHAR_ZERO);
          oct_cnt  = 2'd1;
        end else begin
          // Unknown escapes keep their backslash.
          put_byte(sed_pkg::CHAR_BSLASH, 1'b1, 1'b0);
          put_byte(c, 1'b1, 1'b0);
        end
      end
    endcase
  endfunction

  function automatic void decode_byte(input logic [7:0] c);
    case (dec_mode)
      sed_pkg::MODE_ESC: escape_byte(c);
      sed_pkg::MODE_OCT: begin
        if (c >= sed_pkg::CHAR_ZERO && c <= sed_pkg::CHAR_SEVEN &&
            oct_cnt < sed_pkg::OCT_MAX_DIGITS) begin
          oct_acc = {oct_acc[5:0], 3'b000} + 9'(c - sed_pkg::CHAR_ZERO);
          oct_cnt = oct_cnt + 2'd1;
          if (oct_cnt >= sed_pkg::OCT_MAX_DIGITS) begin
            put_byte(oct_acc[7:0], 1'b1, 1'b0);
            dec_mode = sed_pkg::MODE_NORMAL;
          end
        end else begin
          put_byte(oct_acc[7:0], 1'b1, 1'b0);
          plain_byte(c);
        end
      end
      sed_pkg::MODE_HEX0: begin
        if (hex_digit(c) >= 0) begin
          hex_first = c;
          dec_mode  = sed_pkg::MODE_HEX1;
        end else begin
          put_byte(8'h00, 1'b0, 1'b1);
          plain_byte(c);
        end
      end
      sed_pkg::MODE_HEX1: begin
        if (hex_digit(c) >= 0) begin
          put_byte(8'(hex_digit(hex_first) * 16 + hex_digit(c)), 1'b1, 1'b0);
          dec_mode = sed_pkg::MODE_NORMAL;
        end else begin
          put_byte(hex_first, 1'b1, 1'b1);
          plain_byte(c);
        end
      end
      default: plain_byte(c);
    endcase
  endfunction

  function automatic void flush_pending_escape();
    case (dec_mode)
      sed_pkg::MODE_ESC:  put_byte(sed_pkg::CHAR_BSLASH, 1'b1, 1'b0);
      sed_pkg::MODE_OCT:  put_byte(oct_acc[7:0], 1'b1, 1'b0);
      sed_pkg::MODE_HEX0: put_byte(8'h00, 1'b0, 1'b1);
      sed_pkg::MODE_HEX1: put_byte(hex_first, 1'b1, 1'b1);
      default: ;
    endcase
  endfunction

  function automatic void predict_item(input sed_pkg::in_item_t it);
    logic [7:0] c;
    logic       drop;
    c      = it.in_char;
    drop   = after_cr && (c == sed_pkg::CHAR_LF);
    step_n = 0;
    after_cr = (c == sed_pkg::CHAR_CR);
    if (c == sed_pkg::CHAR_CR) c = sed_pkg::CHAR_LF;
    if (!drop) begin
      if (it.raw_mode) put_byte(c, 1'b1, 1'b0);
      else decode_byte(c);
    end
    if (it.final_char) begin
      flush_pending_escape();
      clear_state();
      if (step_n == 0) put_byte(8'h00, 1'b0, 1'b0);
      step_res[step_n - 1].literal_end = 1'b1;
    end
    if (step_n > 0) step_res[step_n - 1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) decoded_q.insert(decoded_q.size(), step_res[i]);
  endfunction

  function automatic void compare_result(input sed_pkg::out_item_t got);
    sed_pkg::out_item_t want;
    if (decoded_q.size() == 0) begin
      if (err_cnt < REPORT_LIMIT)
        $display("checker: result %0d arrived with none expected: ", result_idx,
                 "byte=%02h valid=%b bad=%b end=%b last=%b",
                 got.out_byte, got.byte_valid, got.bad_hex, got.literal_end,
                 got.run_last);
      err_cnt++;
    end else begin
      want = decoded_q.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.bad_hex !== want.bad_hex || got.literal_end !== want.literal_end ||
          got.run_last !== want.run_last) begin
        if (err_cnt < REPORT_LIMIT)
          $display("checker: result %0d mismatch: ", result_idx,
                   "expected byte=%02h valid=%b bad=%b end=%b last=%b, ",
                   want.out_byte, want.byte_valid, want.bad_hex,
                   want.literal_end, want.run_last,
                   "got byte=%02h valid=%b bad=%b end=%b last=%b",
                   got.out_byte, got.byte_valid,
                   got.bad_hex, got.literal_end, got.run_last);
        err_cnt++;
      end
    end
    result_idx++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      decoded_q.delete();
    end else begin
      // Compare before predicting: a result never belongs to the transaction of the same edge.
      if (out_valid && !out_stall) compare_result(out_data);
      if (in_valid && !in_stall) predict_item(in_data);
    end
    mismatches  <= err_cnt;
    outstanding <= decoded_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for string_escape_decoder_core: clock, reset, stimulus, receiver stalls,
// watchdog and verdict. Depends on sed_pkg and the checker in sed_decode_checker.sv.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS   = 500;
  localparam int SQUEEZE_AFTER  = 150;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int IDLE_LIMIT     = 2000;
  localparam int DRAIN_CYCLES   = 100;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  sed_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  sed_pkg::out_item_t out_data;

  int                 mismatches;
  int                 outstanding;
  int                 idle_cycles = 0;
  int                 random_sent = 0;
  bit                 steady = 1'b0;
  bit                 squeeze = 1'b0;
  bit                 squeeze_done = 1'b0;
  sed_pkg::in_item_t  literal_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  string_escape_decoder_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sed_decode_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add(input logic [7:0] c, input logic raw, input logic fin);
    sed_pkg::in_item_t it;
    it.in_char    = c;
    it.raw_mode   = raw;
    it.final_char = fin;
    literal_q.insert(literal_q.size(), it);
  endfunction

  function automatic void add_str(input string s, input logic raw);
    for (int i = 0; i < s.len(); i++) add(s[i], raw, 1'b0);
  endfunction

  function automatic void mark_final();
    sed_pkg::in_item_t it;
    it = literal_q.pop_back();
    it.final_char = 1'b1;
    literal_q.insert(literal_q.size(), it);
  endfunction

  // One literal: mostly well-formed escape sequences with random content, some raw
  // literals, some pure noise, and the odd raw flag flipped in the middle.
  function automatic void make_literal();
    string hexd = "0123456789abcdefABCDEF";
    string named = "abfnrtv'\"\\";
    string breakers = "gzG-\\ q";
    int    kind;
    int    k;
    logic  raw;
    logic  r;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 8))
        add(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    end else begin
      raw = (kind < 25);
      repeat ($urandom_range(1, 6)) begin
        r = raw ^ ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 9))
          0: add(8'($urandom_range(8'h20, 8'h7E)), r, 1'b0);
          1: add(8'($urandom_range(0, 255)), r, 1'b0);
          2: begin
            add(sed_pkg::CHAR_BSLASH, r, 1'b0);
            k = $urandom_range(0, named.len());
            add((k == named.len()) ? sed_pkg::CHAR_LF : named[k], r, 1'b0);
          end
          3: begin
            add(sed_pkg::CHAR_BSLASH, r, 1'b0);
            repeat ($urandom_range(1, 3))
              add(8'(sed_pkg::CHAR_ZERO + $urandom_range(0, 7)), r, 1'b0);
            if ($urandom_range(0, 2) == 0)
              add(8'(sed_pkg::CHAR_ZERO + $urandom_range(0, 9)), r, 1'b0);
          end
          4: begin
            add(sed_pkg::CHAR_BSLASH, r, 1'b0);
            add(sed_pkg::CHAR_X, r, 1'b0);
            add(hexd[$urandom_range(0, 21)], r, 1'b0);
            add(hexd[$urandom_range(0, 21)], r, 1'b0);
          end
          5: begin
            add(sed_pkg::CHAR_BSLASH, r, 1'b0);
            add(sed_pkg::CHAR_X, r, 1'b0);
            if ($urandom_range(0, 1)) add(hexd[$urandom_range(0, 21)], r, 1'b0);
            k = $urandom_range(0, breakers.len());
            add((k == breakers.len()) ? sed_pkg::CHAR_CR : breakers[k], r, 1'b0);
          end
          6: begin
            add(sed_pkg::CHAR_CR, r, 1'b0);
            add(sed_pkg::CHAR_LF, r, 1'b0);
          end
          7: add(sed_pkg::CHAR_CR, r, 1'b0);
          8: begin
            add(sed_pkg::CHAR_BSLASH, r, 1'b0);
            add(8'($urandom_range(0, 255)), r, 1'b0);
          end
          default: begin
            // Continuation written with CR LF.
            add(sed_pkg::CHAR_BSLASH, r, 1'b0);
            add(sed_pkg::CHAR_CR, r, 1'b0);
            add(sed_pkg::CHAR_LF, r, 1'b0);
          end
        endcase
      end
      // Now and then leave an escape open so that the final transaction has to flush it.
      case ($urandom_range(0, 9))
        0: add(sed_pkg::CHAR_BSLASH, raw, 1'b0);
        1: begin
          add(sed_pkg::CHAR_BSLASH, raw, 1'b0);
          add(sed_pkg::CHAR_X, raw, 1'b0);
        end
        2: begin
          add(sed_pkg::CHAR_BSLASH, raw, 1'b0);
          add(sed_pkg::CHAR_X, raw, 1'b0);
          add(hexd[$urandom_range(0, 21)], raw, 1'b0);
        end
        3: begin
          add(sed_pkg::CHAR_BSLASH, raw, 1'b0);
          add(8'(sed_pkg::CHAR_ZERO + $urandom_range(0, 7)), raw, 1'b0);
        end
        default: ;
      endcase
    end
    mark_final();
  endfunction

  task automatic send_item(input sed_pkg::in_item_t it);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_literals();
    while (literal_q.size() > 0) send_item(literal_q.pop_front());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Bad hex with one digit and with none, octal cut short, octal truncated to a byte.
    add_str("\\x4g\\xz\\18\\777", 1'b0);
    mark_final();
    // CR LF, lone CR, extreme bytes, trailing backslash.
    add(sed_pkg::CHAR_CR, 1'b0, 1'b0);
    add(sed_pkg::CHAR_LF, 1'b0, 1'b0);
    add(sed_pkg::CHAR_CR, 1'b0, 1'b0);
    add(8'hFF, 1'b0, 1'b0);
    add(8'h00, 1'b0, 1'b0);
    add(sed_pkg::CHAR_BSLASH, 1'b0, 1'b1);
    // A raw byte while an escape is pending leaves the escape open.
    add(sed_pkg::CHAR_BSLASH, 1'b0, 1'b0);
    add("n", 1'b1, 1'b0);
    add("t", 1'b0, 1'b1);
    // The final transaction is a dropped LF, so only the end marker comes out.
    add(sed_pkg::CHAR_CR, 1'b0, 1'b0);
    add(sed_pkg::CHAR_LF, 1'b0, 1'b1);
    send_literals();

    while (random_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 6) == 0) steady = !steady;
      make_literal();
      random_sent += literal_q.size();
      if (random_sent >= SQUEEZE_AFTER) squeeze = 1'b1;
      send_literals();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Receiver: free-running stretches alternate with stalls, plus one long hold-off
  // that lets the block fill up and stall the sender.
  initial begin
    int run;
    int stall;
    wait (rst_n);
    forever begin
      if (squeeze && !squeeze_done) begin
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        squeeze_done = 1'b1;
      end else begin
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          out_stall <= 1'b1;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== filelist.f =====
rtl/sed_pkg.sv
rtl/string_escape_decoder_core.sv
sim/sed_decode_checker.sv
sim/tb.sv
